@@ rtl/esa_pkg.sv @@
// Shared types and constants for the exchange sort core.
package esa_pkg;

	localparam int VALUE_W       = 31;
	localparam int MAX_ITEMS_DEF = 64;
	localparam int QDEPTH        = 2;
	localparam int QPTR_W        = $clog2(QDEPTH);
	localparam int QCNT_W        = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               batch_end;
	} item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] sorted_value;
		logic               run_last;
		logic               overflowed;
	} result_t;

	// one queued command: store a value and/or close the batch
	typedef struct packed {
		logic               store;
		logic               close;
		logic               ovf;
		logic [VALUE_W-1:0] value;
	} cmd_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_RDI,
		B_LDI,
		B_SCAN,
		B_EMIT
	} back_state_t;

endpackage

@@ rtl/esa_front.sv @@
// Front end: accepts items, tracks batch fill and drops, builds queue commands.
module esa_front
	import esa_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  item_t item,
	input  logic  q_full,
	output logic  busy,
	output logic  push,
	output cmd_t  cmd
);

	localparam int CW = $clog2(MAX_ITEMS + 1);

	logic [CW-1:0] fill_q;
	logic          drop_q;
	logic          accept;

	assign busy   = q_full;
	assign accept = start && !busy;

	always_comb begin
		cmd.store = fill_q < CW'(MAX_ITEMS);
		cmd.close = item.batch_end;
		cmd.ovf   = drop_q || !cmd.store;
		cmd.value = item.value;
	end

	assign push = accept && (cmd.store || cmd.close);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			drop_q <= 1'b0;
		end else if (accept) begin
			if (cmd.close) begin
				fill_q <= '0;
				drop_q <= 1'b0;
			end else begin
				fill_q <= fill_q + CW'(cmd.store);
				drop_q <= cmd.ovf;
			end
		end
	end

endmodule

@@ rtl/esa_queue.sv @@
// Short command queue between front and back.
module esa_queue
	import esa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic empty,
	output logic full
);

	cmd_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign head  = entry_q[rd_ptr_q];
	assign empty = cnt_q == '0;
	assign full  = cnt_q == QCNT_W'(QDEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

endmodule

@@ rtl/esa_back.sv @@
// Back end: value memory, exchange sort sequencer and sorted readout.
module esa_back
	import esa_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    head,
	input  logic    empty,
	output logic    pop,
	output logic    result_valid,
	output result_t result
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	back_state_t        state_q, state_n;
	logic [VALUE_W-1:0] mem [MAX_ITEMS];
	logic [VALUE_W-1:0] rdata_q;
	logic [VALUE_W-1:0] cur_q;
	logic [CW-1:0]      wr_cnt_q, count_q, j_q, k_q, cnt_n;
	logic [AW-1:0]      i_q, pend_addr_q;
	logic               pend_q, ovf_q, emit_v_q, emit_last_q;

	logic               we, rd_en, swap, scan_issue, scan_done, emit_issue;
	logic [AW-1:0]      waddr, raddr;
	logic [VALUE_W-1:0] wdata;

	assign cnt_n      = wr_cnt_q + CW'(head.store);
	assign swap       = pend_q && (rdata_q < cur_q);
	assign scan_issue = j_q < count_q;
	assign scan_done  = !pend_q && !scan_issue;
	assign emit_issue = k_q < count_q;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!empty && head.close) begin
					state_n = (cnt_n <= CW'(1)) ? B_EMIT : B_RDI;
				end
			end
			B_RDI:  state_n = B_LDI;
			B_LDI:  state_n = B_SCAN;
			B_SCAN: begin
				if (scan_done) begin
					state_n = (CW'(i_q) + CW'(2) >= count_q) ? B_EMIT : B_RDI;
				end
			end
			B_EMIT: begin
				if (!emit_issue) begin
					state_n = B_IDLE;
				end
			end
			default: state_n = B_IDLE;
		endcase
	end

	always_comb begin
		pop   = 1'b0;
		we    = 1'b0;
		waddr = '0;
		wdata = cur_q;
		rd_en = 1'b0;
		raddr = '0;
		unique case (state_q)
			B_IDLE: begin
				pop   = !empty;
				we    = !empty && head.store;
				waddr = wr_cnt_q[AW-1:0];
				wdata = head.value;
			end
			B_RDI: begin
				rd_en = 1'b1;
				raddr = i_q;
			end
			B_LDI: ;
			B_SCAN: begin
				rd_en = scan_issue;
				raddr = j_q[AW-1:0];
				if (swap) begin
					we    = 1'b1;
					waddr = pend_addr_q;
				end else if (scan_done) begin
					we    = 1'b1;
					waddr = i_q;
				end
			end
			B_EMIT: begin
				rd_en = emit_issue;
				raddr = k_q[AW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			wr_cnt_q <= '0;
			count_q  <= '0;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			pend_q   <= 1'b0;
			emit_v_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			emit_v_q <= (state_q == B_EMIT) && emit_issue;
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						if (head.close) begin
							count_q  <= cnt_n;
							wr_cnt_q <= '0;
							i_q      <= '0;
							k_q      <= '0;
						end else begin
							wr_cnt_q <= cnt_n;
						end
					end
				end
				B_RDI: j_q <= CW'(i_q) + CW'(1);
				B_LDI: pend_q <= 1'b0;
				B_SCAN: begin
					pend_q <= scan_issue;
					if (scan_issue) begin
						j_q <= j_q + CW'(1);
					end
					if (scan_done) begin
						i_q <= i_q + AW'(1);
					end
				end
				B_EMIT: begin
					if (emit_issue) begin
						k_q <= k_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && pop && head.close) begin
			ovf_q <= head.ovf;
		end
		if (state_q == B_LDI || (state_q == B_SCAN && swap)) begin
			cur_q <= rdata_q;
		end
		if (state_q == B_SCAN) begin
			pend_addr_q <= j_q[AW-1:0];
		end
		emit_last_q <= k_q == count_q - CW'(1);
	end

	assign result_valid        = emit_v_q;
	assign result.sorted_value = rdata_q;
	assign result.run_last     = emit_last_q;
	assign result.overflowed   = ovf_q;

endmodule

@@ rtl/exchange_sort_ascending_core.sv @@
// Top level: batch exchange sort, ascending, with decoupled front and back.
// Sort: after the closing item the back end sorts the n stored values in place.
// Readout: n results on consecutive cycles, read from memory through a register after the sort.
// Throughput: one item per cycle while the two-entry queue has room. Results cannot stall;
//   busy is high whenever the queue is full, as it can be while the back end sorts or reads out.
// Reset: arst_n clears fill count, drop flag, queue and sequencer; memory is not cleared.
module exchange_sort_ascending_core
	import esa_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    result_valid,
	output result_t result
);

	cmd_t push_cmd, head;
	logic push, pop, q_empty, q_full;

	esa_front #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.q_full (q_full),
		.busy   (busy),
		.push   (push),
		.cmd    (push_cmd)
	);

	esa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	esa_back #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (q_empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

@@ rtl/esa_checker.sv @@
// Port-level checks on the sorted readout, bound to the top level.
module esa_checker
	import esa_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input result_t result
);

	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.run_last |=> result_valid)
		else $error("gap inside a sorted run");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.run_last |=> !result_valid)
		else $error("result right after end of run");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.run_last |=>
			result.sorted_value >= $past(result.sorted_value))
		else $error("run not ascending");

	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.run_last |=>
			result.overflowed == $past(result.overflowed))
		else $error("overflow flag changed within run");

endmodule

bind exchange_sort_ascending_core esa_checker u_esa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result       (result)
);

@@ tb/exchange_sort_ascending_core_test.sv @@
`timescale 1ns / 100ps
// Testbench for the exchange sort core: batches are driven, sorted locally and checked in order.
module exchange_sort_ascending_core_test;
	import esa_pkg::*;

	localparam int DEPTH       = MAX_ITEMS_DEF;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		item_t itm;
		bit    gaps;
		bit    drain;
	} stim_t;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item   = '0;
	logic    busy;
	logic    result_valid;
	result_t result;

	stim_t              pending[$];
	result_t            sorted_q[$];
	logic [VALUE_W-1:0] batch_vals[DEPTH];
	int                 batch_fill = 0;
	bit                 batch_drop = 1'b0;
	bit                 took       = 1'b0;
	int                 gap_left   = 0;
	int                 errors     = 0;

	exchange_sort_ascending_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result)
	);

	always #5 clk = ~clk;

	// store one value; on the closing item sort the batch and queue its results
	task automatic absorb_value(input item_t it);
		logic [VALUE_W-1:0] vals[DEPTH];
		logic [VALUE_W-1:0] t;
		result_t            r;
		if (batch_fill < DEPTH) begin
			batch_vals[batch_fill] = it.value;
			batch_fill++;
		end else begin
			batch_drop = 1'b1;
		end
		if (it.batch_end) begin
			vals = batch_vals;
			for (int i = 0; i < batch_fill; i++)
				for (int j = i + 1; j < batch_fill; j++)
					if (vals[j] < vals[i]) begin
						t       = vals[i];
						vals[i] = vals[j];
						vals[j] = t;
					end
			for (int k = 0; k < batch_fill; k++) begin
				r.sorted_value = vals[k];
				r.run_last     = (k == batch_fill - 1);
				r.overflowed   = batch_drop;
				sorted_q.push_back(r);
			end
			batch_fill = 0;
			batch_drop = 1'b0;
		end
	endtask

	function automatic logic [VALUE_W-1:0] pick_value(input int mode);
		case (mode)
			0: return VALUE_W'($urandom);
			1: return VALUE_W'($urandom_range(0, 5));
			default: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return '1;
					default: return VALUE_W'($urandom);
				endcase
			end
		endcase
	endfunction

	task automatic push_item(input logic [VALUE_W-1:0] v, input bit last, input bit gaps,
			input bit drain);
		stim_t s;
		s.itm.value     = v;
		s.itm.batch_end = last;
		s.gaps          = gaps;
		s.drain         = drain;
		pending.push_back(s);
	endtask

	task automatic push_batch(input int n, input int mode, input bit gaps, input bit drain);
		for (int k = 0; k < n; k++)
			push_item(pick_value(mode), k == n - 1, gaps, drain && k == 0);
	endtask

	// result checks and item acceptance, sampled at the rising edge
	always @(posedge clk) begin
		result_t want;
		took = 1'b0;
		if (arst_n) begin
			if (result_valid) begin
				if (sorted_q.size() == 0) begin
					$error("unexpected result: %p", result);
					errors++;
				end else begin
					want = sorted_q.pop_front();
					if (result.sorted_value !== want.sorted_value) begin
						$error("sorted_value: expected %0h, got %0h",
							want.sorted_value, result.sorted_value);
						errors++;
					end
					if (result.run_last !== want.run_last) begin
						$error("run_last: expected %0b, got %0b", want.run_last,
							result.run_last);
						errors++;
					end
					if (result.overflowed !== want.overflowed) begin
						$error("overflowed: expected %0b, got %0b", want.overflowed,
							result.overflowed);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				absorb_value(item);
				took = 1'b1;
			end
		end
	end

	// item driver, changes inputs at the falling edge
	always @(negedge clk) begin
		if (arst_n && (!start || took)) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending.size() == 0) begin
				start <= 1'b0;
			end else if (pending[0].drain && sorted_q.size() != 0) begin
				start <= 1'b0;
			end else if (pending[0].gaps && $urandom_range(0, 4) == 0) begin
				gap_left = $urandom_range(0, 11);
				start <= 1'b0;
			end else begin
				item  <= pending[0].itm;
				start <= 1'b1;
				void'(pending.pop_front());
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("simulation failed");
		$finish;
	end

	initial begin
		int added;
		// directed: extremes, ties, reversed order
		push_item('1, 1'b1, 1'b1, 1'b0);
		push_item('0, 1'b1, 1'b1, 1'b0);
		push_item('1, 1'b0, 1'b1, 1'b0);
		push_item('0, 1'b1, 1'b1, 1'b0);
		push_item(31'd7, 1'b0, 1'b1, 1'b0);
		push_item(31'd7, 1'b0, 1'b1, 1'b0);
		push_item(31'd7, 1'b1, 1'b1, 1'b0);
		push_item(31'h4000_0000, 1'b0, 1'b1, 1'b0);
		push_item('1, 1'b0, 1'b1, 1'b0);
		push_item(31'd1, 1'b0, 1'b1, 1'b0);
		push_item('0, 1'b0, 1'b1, 1'b0);
		push_item(31'h2AAA_AAAA, 1'b0, 1'b1, 1'b0);
		push_item(31'h5555_5555, 1'b1, 1'b1, 1'b0);
		push_item(31'd3, 1'b0, 1'b1, 1'b0);
		push_item(31'd1, 1'b0, 1'b1, 1'b0);
		push_item(31'd3, 1'b0, 1'b1, 1'b0);
		push_item(31'd1, 1'b0, 1'b1, 1'b0);
		push_item(31'd2, 1'b1, 1'b1, 1'b0);
		// full store, then overflow with the closing item dropped
		push_batch(DEPTH + 1, 2, 1'b1, 1'b1);
		added = 0;
		while (added < 20) begin
			int n;
			n = $urandom_range(1, 10);
			push_batch(n, $urandom_range(0, 2), 1'b1, $urandom_range(0, 3) == 0);
			added += n;
		end
		added = 0;
		while (added < 15) begin
			int n;
			n = $urandom_range(1, 8);
			push_batch(n, $urandom_range(0, 2), 1'b0, 1'b0);
			added += n;
		end
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		while (pending.size() != 0 || start) @(negedge clk);
		while (sorted_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
